@@ rtl/sha1_pkg.sv @@
// SHA-1 package: constants, front-to-back queue entry type, round helpers.
// Used by all sha1 modules; depends on nothing.
package sha1_pkg;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // classified command passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eom;
    } sha1_cmd_t;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        begin
            if (r < 7'd20)
                k = 32'h5A827999;
            else if (r < 7'd40)
                k = 32'h6ED9EBA1;
            else if (r < 7'd60)
                k = 32'h8F1BBCDC;
            else
                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (r < 7'd20)
                f = (b & c) | (~b & d);
            else if (r < 7'd40 || r >= 7'd60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (b & d) | (c & d);
            return f;
        end
    endfunction
endpackage

@@ rtl/sha1_message_digest.sv @@
// SHA-1 digest top level: front command queue plus back compression engine.
// Depends on sha1_pkg, sha1_front, sha1_back.
//
// channel | dir | tdata                         | tuser / tlast
// s_axis  | in  | [7:0] data_byte               | tuser: has_byte, tlast: end_of_message
// m_axis  | out | [31:0] digest_word            | tuser: word_index, tlast: last_word
//
// Each byte is packed into the current block; every 64th byte starts its compression.
// End of message pads byte per cycle, compresses once or twice, then gives 5 beats.
// Reset loads the initial chaining values and clears bit count and block position.
// The four-entry input queue keeps accepting until full while the engine compresses
// or output stalls.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic        s_axis_tuser,  // has_byte
    input  logic        s_axis_tlast,  // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // digest_word
    output logic [2:0]  m_axis_tuser,  // word_index
    output logic        m_axis_tlast   // last_word
);
    import sha1_pkg::*;

    sha1_cmd_t in_cmd, q_cmd;
    logic      q_valid, q_ready;

    assign in_cmd = '{data: s_axis_tdata, has: s_axis_tuser, eom: s_axis_tlast};

    sha1_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    sha1_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
    );
endmodule

@@ rtl/sha1_front.sv @@
// Front part: accepts input beats and queues them as commands.
// Depends on sha1_pkg.
module sha1_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha1_pkg::sha1_cmd_t in_cmd,
    output logic               q_valid,
    input  logic               q_ready,
    output sha1_pkg::sha1_cmd_t q_cmd
);
    import sha1_pkg::*;
    localparam int AW = $clog2(QUEUE_DEPTH);

    sha1_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready = (cnt_reg != QUEUE_DEPTH[AW:0]);
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_cmd;
    end
endmodule

@@ rtl/sha1_back.sv @@
// Back part: byte packing, padding, 80-round compression, digest output.
// Depends on sha1_pkg.
module sha1_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  sha1_pkg::sha1_cmd_t q_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_word,
    output logic [2:0]         out_index,
    output logic               out_last
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1; // emitting pad / length bytes
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [5:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic        pad_reg;     // padding in progress
    logic        first_reg;   // 0x80 not yet written
    logic        len_ok_reg;  // length field goes at the end of this block
    logic [2:0]  oi_reg;

    logic        put;
    logic [7:0]  put_byte;
    logic [3:0]  widx;
    logic [4:0]  sh;
    logic [31:0] wnew, wcur, t;
    logic [3:0]  ri;

    assign q_ready   = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign out_word  = h_reg[oi_reg];
    assign out_index = oi_reg;
    assign out_last  = (oi_reg == 3'd4);

    // byte selected for the current put
    always_comb
    begin
        put      = 1'b0;
        put_byte = q_cmd.data;
        if (st_reg == S_IDLE && q_valid && q_cmd.has)
            put = 1'b1;
        if (st_reg == S_PAD)
        begin
            put = 1'b1;
            if (first_reg)
                put_byte = PAD_BYTE;
            else if (len_ok_reg && pos_reg >= 6'd56)
                put_byte = len_reg[8'd63 - {2'b0, pos_reg[2:0], 3'b0} -: 8];
            else
                put_byte = 8'h00;
        end
        widx = pos_reg[5:2];
        sh   = 5'd24 - {pos_reg[1:0], 3'b0};
    end

    assign ri   = rnd_reg[3:0];
    assign wnew = {w_reg[ri + 4'd13] ^ w_reg[ri + 4'd8] ^ w_reg[ri + 4'd2] ^ w_reg[ri]};
    assign wcur = (rnd_reg >= 7'd16) ? {wnew[30:0], wnew[31]} : w_reg[ri];
    assign t    = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                  + e_reg + wcur + round_k(rnd_reg);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
                if (q_valid)
                begin
                    if (q_cmd.has && pos_reg == 6'd63)
                        st_next = S_COMP;
                    else if (q_cmd.eom)
                        st_next = S_PAD;
                end
            S_PAD:
                if (pos_reg == 6'd63)
                    st_next = S_COMP;
            S_COMP:
                if (rnd_reg == 7'd79)
                    st_next = S_ADD;
            S_ADD:
                if (pad_reg)
                    st_next = (len_reg == 64'd1) ? S_OUT : S_PAD;
                else
                    st_next = S_IDLE;
            S_OUT:
                if (out_ready && oi_reg == 3'd4)
                    st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            h_reg[0]   <= H0;
            h_reg[1]   <= H1;
            h_reg[2]   <= H2;
            h_reg[3]   <= H3;
            h_reg[4]   <= H4;
            bits_reg   <= '0;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            pad_reg    <= 1'b0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            oi_reg     <= '0;
            len_reg    <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (put)
                pos_reg <= pos_reg + 6'd1;
            if (st_reg == S_IDLE && q_valid)
            begin
                if (q_cmd.has)
                    bits_reg <= bits_reg + 64'd8;
                if (q_cmd.eom)
                begin
                    pad_reg    <= 1'b1;
                    first_reg  <= 1'b1;
                    len_ok_reg <= 1'b0;
                    len_reg    <= bits_reg + (q_cmd.has ? 64'd8 : 64'd0);
                end
            end
            if (st_reg == S_PAD)
            begin
                first_reg <= 1'b0;
                // 0x80 below byte 56 leaves room for the length in this block
                if (first_reg && pos_reg < 6'd56)
                    len_ok_reg <= 1'b1;
            end
            if (st_reg == S_COMP)
                rnd_reg <= rnd_reg + 7'd1;
            if (st_reg == S_ADD)
            begin
                rnd_reg  <= '0;
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
                if (pad_reg)
                    len_ok_reg <= 1'b1;
            end
            // length bytes written: mark block as final by len sentinel
            if (st_reg == S_PAD && pos_reg == 6'd63 && len_ok_reg)
                len_reg <= 64'd1;
            if (st_reg == S_OUT && out_ready)
            begin
                if (oi_reg == 3'd4)
                begin
                    oi_reg    <= '0;
                    pad_reg   <= 1'b0;
                    bits_reg  <= '0;
                    pos_reg   <= '0;
                    h_reg[0]  <= H0;
                    h_reg[1]  <= H1;
                    h_reg[2]  <= H2;
                    h_reg[3]  <= H3;
                    h_reg[4]  <= H4;
                end
                else
                    oi_reg <= oi_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
            w_reg[widx] <= (w_reg[widx] & ~(32'hFF << sh)) | ({24'd0, put_byte} << sh);
        if (st_reg == S_COMP)
        begin
            if (rnd_reg >= 7'd16)
                w_reg[ri] <= wcur;
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end
endmodule

@@ test/tb.sv @@
// Self-checking bench for sha1_message_digest: random and directed messages, SHA-1 digest
// predicted in-bench and compared beat by beat. Depends on the RTL only.
module tb;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state
    logic [7:0]   msg_block [64];
    logic [31:0]  hash_chain [5];
    logic [63:0]  msg_bits;
    logic [5:0]   block_pos;
    digest_beat_t pending_digest [$];

    int  error_count;
    int  idle_count;
    bit  calm;

    sha1_message_digest i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void reset_chain();
        hash_chain[0] = 32'h67452301;
        hash_chain[1] = 32'hEFCDAB89;
        hash_chain[2] = 32'h98BADCFE;
        hash_chain[3] = 32'h10325476;
        hash_chain[4] = 32'hC3D2E1F0;
        msg_bits  = '0;
        block_pos = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
                                  ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + w[r % 16] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        msg_block[block_pos] = v;
        block_pos = block_pos + 6'd1;
        if (block_pos == 6'd0)
            compress_block();
    endfunction

    // one accepted beat into the predictor
    function automatic void predict_digest(input logic [7:0] data, input logic has,
                                           input logic eom);
        logic [63:0] len;
        digest_beat_t exp_beat;
        if (has)
        begin
            absorb_byte(data);
            msg_bits += 64'd8;
        end
        if (eom)
        begin
            len = msg_bits;
            absorb_byte(8'h80);
            while (block_pos != 6'd56)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(len[63 - 8*i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                exp_beat.word  = hash_chain[i];
                exp_beat.index = 3'(i);
                exp_beat.last  = (i == 4);
                pending_digest.push_back(exp_beat);
            end
            reset_chain();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit want_idle();
        return !calm && ($urandom_range(99) < 28);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic has, input logic eom);
        if (want_idle())
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has;
        s_axis_tlast  <= eom;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_digest(data, has, eom);
    endtask

    task automatic send_message(input int nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            // occasional empty beat inside a message
            if ($urandom_range(9) == 0)
                send_byte(8'($urandom), 1'b0, 1'b0);
            send_byte(8'($urandom), 1'b1, i == nbytes - 1);
        end
        if (nbytes == 0)
            send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_and_edges();
        send_byte(8'h00, 1'b0, 1'b1);           // empty message
        send_byte(8'hFF, 1'b1, 1'b1);           // byte and end together
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h5A, 1'b0, 1'b0);           // ignored
        send_byte(8'hA5, 1'b0, 1'b1);           // end with no byte after an ignored one
    endtask

    task automatic test_abc();
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_pad_boundaries();
        // lengths that put the length field at the block edge or force an extra block
        send_message(55);
        send_message(56);
        drain_digests();
        send_message(64);
    endtask

    task automatic test_random_messages();
        int sent;
        sent = 0;
        while (sent < 300)
        begin
            int n;
            calm = (sent >= 150 && sent < 250);
            n = ($urandom_range(7) == 0) ? $urandom_range(64, 130) : $urandom_range(0, 20);
            send_message(n);
            sent += n + 1;
            if ($urandom_range(7) == 0)
                drain_digests();
        end
        calm = 1'b0;
    endtask

    // sink side: random backpressure and beat checks
    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digest.size() == 0)
                report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
            else
            begin
                exp_beat = pending_digest.pop_front();
                if (m_axis_tdata !== exp_beat.word)
                    report_mismatch($sformatf("word %0d: got %h want %h", exp_beat.index,
                                              m_axis_tdata, exp_beat.word));
                if (m_axis_tuser !== exp_beat.index)
                    report_mismatch($sformatf("index: got %0d want %0d", m_axis_tuser,
                                              exp_beat.index));
                if (m_axis_tlast !== exp_beat.last)
                    report_mismatch($sformatf("last: got %b want %b", m_axis_tlast,
                                              exp_beat.last));
            end
        end
        m_axis_tready <= !want_idle();
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_count <= 0;
        else if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("timeout");
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    initial
    begin
        error_count = 0;
        idle_count  = 0;
        calm        = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        reset_chain();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_edges();
        test_abc();
        test_pad_boundaries();
        test_random_messages();

        drain_digests();
        repeat (300) @(posedge clk);
        if (error_count == 0 && pending_digest.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_back.sv
rtl/sha1_message_digest.sv
test/tb.sv
